// ===== hw/rtl/assert_macros.svh =====
// assertion helpers shared by the rtl files
// every check is clocked on clock and switched off while reset is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the cycle after the antecedent
`define HCC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hcc check failed: next-cycle property");

// consequent must hold in the same cycle as the antecedent
`define HCC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hcc check failed: same-cycle property");

`endif

// ===== hw/rtl/hcc_pkg.sv =====
// ----------------------------------------------------------------------------
// hcc_pkg
// Types, codes and helpers shared by the heater cycle controller files.
// ----------------------------------------------------------------------------
`default_nettype none

package hcc_pkg;

   localparam int TEMP_W = 10;
   localparam int TIME_W = 32;
   localparam int CSR_INDEX_W = 3;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_HEAT_LIMIT        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_TIME_MS      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BAND_BLUE_LIMIT   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BAND_YELLOW_LIMIT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BAND_PURPLE_LIMIT = 3'd4;

   // register reset values
   localparam logic [TEMP_W-1:0] HEAT_LIMIT_RST        = 10'd300;
   localparam logic [TIME_W-1:0] HOLD_TIME_MS_RST      = 32'd10000;
   localparam logic [TEMP_W-1:0] BAND_BLUE_LIMIT_RST   = 10'd150;
   localparam logic [TEMP_W-1:0] BAND_YELLOW_LIMIT_RST = 10'd230;
   localparam logic [TEMP_W-1:0] BAND_PURPLE_LIMIT_RST = 10'd300;

   // operating modes
   localparam logic [1:0] MODE_STANDBY  = 2'd0;
   localparam logic [1:0] MODE_HEATING  = 2'd1;
   localparam logic [1:0] MODE_FINISHED = 2'd2;

   // led colors
   localparam logic [2:0] LED_OFF    = 3'd0;
   localparam logic [2:0] LED_WHITE  = 3'd1;
   localparam logic [2:0] LED_GREEN  = 3'd2;
   localparam logic [2:0] LED_BLUE   = 3'd3;
   localparam logic [2:0] LED_YELLOW = 3'd4;
   localparam logic [2:0] LED_PURPLE = 3'd5;
   localparam logic [2:0] LED_RED    = 3'd6;

   // led patterns
   localparam logic [1:0] PAT_STEADY   = 2'd0;
   localparam logic [1:0] PAT_STANDBY  = 2'd1;
   localparam logic [1:0] PAT_HEATING  = 2'd2;
   localparam logic [1:0] PAT_FINISHED = 2'd3;

   typedef struct packed {
      logic [TIME_W-1:0] now_ms;
      logic [TEMP_W-1:0] temperature;
      logic              press_event;
      logic              button_level;
   } req_type;

   typedef struct packed {
      logic       relay_on;
      logic [2:0] led_color;
      logic [1:0] led_pattern;
      logic [1:0] mode_now;
   } rsp_type;

   typedef struct packed {
      logic [TEMP_W-1:0] heat_limit;
      logic [TIME_W-1:0] hold_time_ms;
      logic [TEMP_W-1:0] band_blue_limit;
      logic [TEMP_W-1:0] band_yellow_limit;
      logic [TEMP_W-1:0] band_purple_limit;
   } cfg_type;

   // first band whose limit is met wins
   function automatic logic [2:0] band_color(
      input logic [TEMP_W-1:0] temp,
      input cfg_type           cfg
   );
      logic [2:0] color;
      if (temp <= cfg.band_blue_limit) begin
         color = LED_BLUE;
      end else if (temp <= cfg.band_yellow_limit) begin
         color = LED_YELLOW;
      end else if (temp <= cfg.band_purple_limit) begin
         color = LED_PURPLE;
      end else begin
         color = LED_RED;
      end
      return color;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/heater_cycle_controller.sv =====
// ----------------------------------------------------------------------------
// heater_cycle_controller
// Heater relay and status led control, one control pass per request beat.
// ----------------------------------------------------------------------------
//
//   port group  direction  handshake          payload
//   req_        in         req_valid/stall    hcc_pkg::req_type
//   rsp_        out        rsp_valid/stall    hcc_pkg::rsp_type
//   csr_        in         csr_valid/ready    csr_index, csr_data
//
// One beat per cycle sustained while rsp_stall is low; an accepted beat sits in the input
// register, and its result is then held in the result register and driven on rsp_.
// req_stall comes from the skid flop, never combinationally from rsp_stall;
// a held rsp_ absorbs three beats (result, input, skid) before req_stall rises.
// Synchronous reset clears the mode machine, timer and configuration to
// their defaults; csr_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module heater_cycle_controller (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire hcc_pkg::req_type                 req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output hcc_pkg::rsp_type                      rsp_data,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [hcc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [hcc_pkg::TIME_W-1:0]       csr_data
);

   hcc_pkg::req_type sk_data;
   logic             sk_valid;
   logic             sk_stall;

   logic             in_vld_ff;
   hcc_pkg::req_type in_data_ff;
   logic             out_vld_ff;
   hcc_pkg::rsp_type out_data_ff;

   logic             pipe_en;
   logic             pass_en;
   hcc_pkg::cfg_type cfg;
   hcc_pkg::rsp_type result;

   assign csr_ready = 1'b1;
   assign pipe_en   = ~out_vld_ff | ~rsp_stall;
   assign pass_en   = in_vld_ff & pipe_en;
   assign sk_stall  = in_vld_ff & ~pipe_en;
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

   hcc_skid u_skid (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_valid),
      .up_stall (req_stall),
      .up_data  (req_data),
      .dn_valid (sk_valid),
      .dn_stall (sk_stall),
      .dn_data  (sk_data)
   );

   hcc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid & csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   hcc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .pass_en (pass_en),
      .item    (in_data_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (!sk_stall) begin
            in_vld_ff <= sk_valid;
         end
         if (pipe_en) begin
            out_vld_ff <= in_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!sk_stall && sk_valid) begin
         in_data_ff <= sk_data;
      end
      if (pass_en) begin
         out_data_ff <= result;
      end
   end

   // skid only fills behind a held input register
   `HCC_ASSERT_SAME(a_skid_behind_input, req_stall, in_vld_ff)
   `HCC_ASSERT_NEXT(a_pass_lands, pass_en, out_vld_ff)

endmodule

`default_nettype wire

// ===== hw/rtl/hcc_skid.sv =====
// ----------------------------------------------------------------------------
// hcc_skid
// Skid buffer on the request side, so req_stall comes straight from a flop.
// ----------------------------------------------------------------------------
`default_nettype none

module hcc_skid (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            up_valid,
   output logic                 up_stall,
   input  wire hcc_pkg::req_type up_data,
   output logic                 dn_valid,
   input  wire logic            dn_stall,
   output hcc_pkg::req_type     dn_data
);

   logic             skid_vld_ff;
   logic             skid_vld_in;
   hcc_pkg::req_type skid_data_ff;

   assign up_stall = skid_vld_ff;
   assign dn_valid = skid_vld_ff | up_valid;
   assign dn_data  = skid_vld_ff ? skid_data_ff : up_data;

   always_comb begin
      skid_vld_in = skid_vld_ff;
      if (skid_vld_ff && !dn_stall) begin
         skid_vld_in = 1'b0;
      end else if (!skid_vld_ff && up_valid && dn_stall) begin
         skid_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_vld_ff <= 1'b0;
      end else begin
         skid_vld_ff <= skid_vld_in;
      end
   end

   // park the beat that arrived while downstream stalled
   always_ff @(posedge clock) begin
      if (!skid_vld_ff && up_valid && dn_stall) begin
         skid_data_ff <= up_data;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/hcc_csr.sv =====
// ----------------------------------------------------------------------------
// hcc_csr
// Configuration registers: limits, hold time and color band edges.
// ----------------------------------------------------------------------------
`default_nettype none

module hcc_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                wr_en,
   input  wire logic [hcc_pkg::CSR_INDEX_W-1:0]     wr_index,
   input  wire logic [hcc_pkg::TIME_W-1:0]          wr_data,
   output hcc_pkg::cfg_type                         cfg
);

   hcc_pkg::cfg_type cfg_ff;
   hcc_pkg::cfg_type cfg_in;

   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            hcc_pkg::CSR_HEAT_LIMIT: begin
               cfg_in.heat_limit = wr_data[hcc_pkg::TEMP_W-1:0];
            end
            hcc_pkg::CSR_HOLD_TIME_MS: begin
               cfg_in.hold_time_ms = wr_data;
            end
            hcc_pkg::CSR_BAND_BLUE_LIMIT: begin
               cfg_in.band_blue_limit = wr_data[hcc_pkg::TEMP_W-1:0];
            end
            hcc_pkg::CSR_BAND_YELLOW_LIMIT: begin
               cfg_in.band_yellow_limit = wr_data[hcc_pkg::TEMP_W-1:0];
            end
            hcc_pkg::CSR_BAND_PURPLE_LIMIT: begin
               cfg_in.band_purple_limit = wr_data[hcc_pkg::TEMP_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.heat_limit        <= hcc_pkg::HEAT_LIMIT_RST;
         cfg_ff.hold_time_ms      <= hcc_pkg::HOLD_TIME_MS_RST;
         cfg_ff.band_blue_limit   <= hcc_pkg::BAND_BLUE_LIMIT_RST;
         cfg_ff.band_yellow_limit <= hcc_pkg::BAND_YELLOW_LIMIT_RST;
         cfg_ff.band_purple_limit <= hcc_pkg::BAND_PURPLE_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/hcc_core.sv =====
// ----------------------------------------------------------------------------
// hcc_core
// Mode machine, press lockout, hold timer and led selection for one pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module hcc_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             pass_en,
   input  wire hcc_pkg::req_type item,
   input  wire hcc_pkg::cfg_type cfg,
   output hcc_pkg::rsp_type      result
);

   logic [1:0]                  mode_ff;
   logic [1:0]                  mode_in;
   logic [hcc_pkg::TEMP_W-1:0]  last_temp_ff;
   logic                        lockout_ff;
   logic                        lockout_in;
   logic                        armed_ff;
   logic                        armed_in;
   logic [hcc_pkg::TIME_W-1:0]  start_ms_ff;
   logic [hcc_pkg::TIME_W-1:0]  start_ms_in;

   logic                        press_take;
   logic [1:0]                  mode_pressed;
   logic                        lock_set;
   logic                        heating;
   logic                        reached;
   logic                        arm;
   logic [hcc_pkg::TIME_W-1:0]  elapsed;
   logic                        expire;

   assign press_take = item.press_event & ~lockout_ff;
   assign lock_set   = press_take | lockout_ff;
   assign lockout_in = lock_set & item.button_level;
   assign heating    = (mode_ff == hcc_pkg::MODE_HEATING);
   assign reached    = (item.temperature >= cfg.heat_limit);
   // wraps modulo 2^32 like the timestamp
   assign elapsed    = item.now_ms - start_ms_ff;
   assign arm        = heating & reached & ~armed_ff;
   assign expire     = heating & ~arm & armed_ff & (elapsed >= cfg.hold_time_ms);

   always_comb begin
      mode_pressed = mode_ff;
      if (press_take) begin
         if (mode_ff == hcc_pkg::MODE_STANDBY) begin
            mode_pressed = (last_temp_ff >= cfg.heat_limit) ?
                           hcc_pkg::MODE_FINISHED : hcc_pkg::MODE_HEATING;
         end else begin
            mode_pressed = hcc_pkg::MODE_STANDBY;
         end
      end
   end

   always_comb begin
      mode_in     = expire ? hcc_pkg::MODE_FINISHED : mode_pressed;
      armed_in    = armed_ff;
      start_ms_in = start_ms_ff;
      if (arm) begin
         armed_in    = 1'b1;
         start_ms_in = item.now_ms;
      end else if (expire) begin
         armed_in    = 1'b0;
         start_ms_in = '0;
      end
   end

   // led follows the mode before the timer gets its say
   always_comb begin
      result.relay_on = heating;
      result.mode_now = mode_in;
      if (item.button_level) begin
         result.led_color   = lockout_in ? hcc_pkg::LED_OFF : hcc_pkg::LED_WHITE;
         result.led_pattern = hcc_pkg::PAT_STEADY;
      end else begin
         case (mode_pressed)
            hcc_pkg::MODE_STANDBY: begin
               result.led_color   = hcc_pkg::LED_GREEN;
               result.led_pattern = hcc_pkg::PAT_STANDBY;
            end
            hcc_pkg::MODE_HEATING: begin
               result.led_color   = hcc_pkg::band_color(item.temperature, cfg);
               result.led_pattern = hcc_pkg::PAT_HEATING;
            end
            default: begin
               result.led_color   = hcc_pkg::band_color(item.temperature, cfg);
               result.led_pattern = hcc_pkg::PAT_FINISHED;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= hcc_pkg::MODE_STANDBY;
         last_temp_ff <= '0;
         lockout_ff   <= 1'b0;
         armed_ff     <= 1'b0;
         start_ms_ff  <= '0;
      end else if (pass_en) begin
         mode_ff      <= mode_in;
         last_temp_ff <= item.temperature;
         lockout_ff   <= lockout_in;
         armed_ff     <= armed_in;
         start_ms_ff  <= start_ms_in;
      end
   end

   `HCC_ASSERT_NEXT(a_expire_finishes, pass_en && expire,
      mode_ff == hcc_pkg::MODE_FINISHED && !armed_ff && start_ms_ff == '0)
   `HCC_ASSERT_NEXT(a_arm_records_time, pass_en && arm,
      armed_ff && start_ms_ff == $past(item.now_ms))
   `HCC_ASSERT_NEXT(a_press_locks, pass_en && press_take && item.button_level,
      lockout_ff)
   `HCC_ASSERT_SAME(a_timer_only_heating, expire || arm, heating)

endmodule

`default_nettype wire

// ===== tb/sv/hcc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcc_checker
// Watches the request, result and csr channels of the heater cycle
// controller, predicts each control pass and compares every result beat.
// ----------------------------------------------------------------------------
module hcc_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  hcc_pkg::req_type                req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  hcc_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [hcc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hcc_pkg::TIME_W-1:0]      csr_data,
   output int                              mismatch_count,
   output int                              outstanding
);

   hcc_pkg::cfg_type                regs;
   logic [1:0]                      heat_mode;
   logic [hcc_pkg::TEMP_W-1:0]      prior_temp;
   logic                            press_blocked;
   logic                            timer_running;
   logic [hcc_pkg::TIME_W-1:0]      timer_origin;

   hcc_pkg::rsp_type   awaited_outputs[$];
   hcc_pkg::rsp_type   want;
   int                 field_errors = 0;

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
   end

   function automatic logic [2:0] shade_for(input logic [hcc_pkg::TEMP_W-1:0] temp);
      logic [2:0] shade;
      if (temp <= regs.band_blue_limit) begin
         shade = hcc_pkg::LED_BLUE;
      end else if (temp <= regs.band_yellow_limit) begin
         shade = hcc_pkg::LED_YELLOW;
      end else if (temp <= regs.band_purple_limit) begin
         shade = hcc_pkg::LED_PURPLE;
      end else begin
         shade = hcc_pkg::LED_RED;
      end
      return shade;
   endfunction

   // one control pass: updates the shadow state, returns the outputs
   function automatic hcc_pkg::rsp_type predict_pass(input hcc_pkg::req_type item);
      hcc_pkg::rsp_type           outputs;
      logic [1:0]                 entry_mode;
      logic [hcc_pkg::TIME_W-1:0] elapsed;
      entry_mode = heat_mode;
      if (item.press_event && !press_blocked) begin
         if (heat_mode == hcc_pkg::MODE_STANDBY) begin
            heat_mode = (prior_temp >= regs.heat_limit) ? hcc_pkg::MODE_FINISHED :
                                                          hcc_pkg::MODE_HEATING;
         end else begin
            heat_mode = hcc_pkg::MODE_STANDBY;
         end
         press_blocked = 1'b1;
      end
      if (!item.button_level) begin
         press_blocked = 1'b0;
      end
      prior_temp = item.temperature;

      if (item.button_level) begin
         outputs.led_color   = press_blocked ? hcc_pkg::LED_OFF : hcc_pkg::LED_WHITE;
         outputs.led_pattern = hcc_pkg::PAT_STEADY;
      end else if (heat_mode == hcc_pkg::MODE_STANDBY) begin
         outputs.led_color   = hcc_pkg::LED_GREEN;
         outputs.led_pattern = hcc_pkg::PAT_STANDBY;
      end else begin
         outputs.led_color   = shade_for(item.temperature);
         outputs.led_pattern = (heat_mode == hcc_pkg::MODE_HEATING) ? hcc_pkg::PAT_HEATING :
                                                                      hcc_pkg::PAT_FINISHED;
      end

      // the timer only runs when the pass began in heating
      if (entry_mode == hcc_pkg::MODE_HEATING) begin
         elapsed = item.now_ms - timer_origin;
         if (item.temperature >= regs.heat_limit && !timer_running) begin
            timer_running = 1'b1;
            timer_origin  = item.now_ms;
         end else if (timer_running && elapsed >= regs.hold_time_ms) begin
            timer_running = 1'b0;
            timer_origin  = '0;
            heat_mode     = hcc_pkg::MODE_FINISHED;
         end
      end

      outputs.relay_on = (entry_mode == hcc_pkg::MODE_HEATING);
      outputs.mode_now = heat_mode;
      return outputs;
   endfunction

   task automatic compare_field(input string field, input logic [2:0] expected_value,
                                input logic [2:0] actual_value);
      if (actual_value !== expected_value) begin
         field_errors++;
         if (field_errors <= 10) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field,
                     expected_value, actual_value);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         regs.heat_limit        = hcc_pkg::HEAT_LIMIT_RST;
         regs.hold_time_ms      = hcc_pkg::HOLD_TIME_MS_RST;
         regs.band_blue_limit   = hcc_pkg::BAND_BLUE_LIMIT_RST;
         regs.band_yellow_limit = hcc_pkg::BAND_YELLOW_LIMIT_RST;
         regs.band_purple_limit = hcc_pkg::BAND_PURPLE_LIMIT_RST;
         heat_mode     = hcc_pkg::MODE_STANDBY;
         prior_temp    = '0;
         press_blocked = 1'b0;
         timer_running = 1'b0;
         timer_origin  = '0;
         awaited_outputs.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               hcc_pkg::CSR_HEAT_LIMIT:
                  regs.heat_limit = csr_data[hcc_pkg::TEMP_W-1:0];
               hcc_pkg::CSR_HOLD_TIME_MS:
                  regs.hold_time_ms = csr_data;
               hcc_pkg::CSR_BAND_BLUE_LIMIT:
                  regs.band_blue_limit = csr_data[hcc_pkg::TEMP_W-1:0];
               hcc_pkg::CSR_BAND_YELLOW_LIMIT:
                  regs.band_yellow_limit = csr_data[hcc_pkg::TEMP_W-1:0];
               hcc_pkg::CSR_BAND_PURPLE_LIMIT:
                  regs.band_purple_limit = csr_data[hcc_pkg::TEMP_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            awaited_outputs.push_back(predict_pass(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_outputs.size() == 0) begin
               field_errors++;
               if (field_errors <= 10) begin
                  $display("%0t: result beat with nothing expected, got %h", $time, rsp_data);
               end
            end else begin
               want = awaited_outputs.pop_front();
               compare_field("relay_on", 3'(want.relay_on), 3'(rsp_data.relay_on));
               compare_field("led_color", want.led_color, rsp_data.led_color);
               compare_field("led_pattern", 3'(want.led_pattern), 3'(rsp_data.led_pattern));
               compare_field("mode_now", 3'(want.mode_now), 3'(rsp_data.mode_now));
            end
         end
      end
      mismatch_count <= field_errors;
      outstanding    <= awaited_outputs.size();
   end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives control passes and csr writes into the heater cycle controller with
// random gaps and stalls; the checker beside the block scores the results.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CYCLE_LIMIT      = 200000;
   localparam int HOLD_OFF_CYCLES  = 300;
   localparam int RANDOM_PHASES    = 8;
   localparam int PASSES_PER_PHASE = 150;
   localparam int TEMP_BITS        = hcc_pkg::TEMP_W;
   localparam int JUNK_BITS        = hcc_pkg::TIME_W - hcc_pkg::TEMP_W;
   localparam int INDEX_BITS       = hcc_pkg::CSR_INDEX_W;
   localparam int TEMP_TOP         = (1 << hcc_pkg::TEMP_W) - 1;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   hcc_pkg::req_type                req_data = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   hcc_pkg::rsp_type                rsp_data;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [hcc_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [hcc_pkg::TIME_W-1:0]      csr_data = '0;

   int                     mismatch_count;
   int                     outstanding;
   int                     cycle_count = 0;
   int                     send_idle_pct = 8;
   int                     recv_idle_pct = 8;
   logic                   hold_off_toggle = 1'b0;

   // stimulus scenario state
   logic [hcc_pkg::TIME_W-1:0] clock_ms = 32'hFFFF_F000;
   logic [hcc_pkg::TEMP_W-1:0] temp_now = '0;
   logic [hcc_pkg::TEMP_W-1:0] limit_now = hcc_pkg::HEAT_LIMIT_RST;

   heater_cycle_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   hcc_checker pass_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL heater_cycle_controller");
         $finish;
      end
   end

   // result side: random stalls, plus a long hold-off on request
   initial begin : receiver
      int   hold_left;
      logic seen_toggle;
      hold_left   = 0;
      seen_toggle = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_toggle != seen_toggle) begin
            seen_toggle = hold_off_toggle;
            hold_left   = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   task automatic drive_pass(input logic [hcc_pkg::TIME_W-1:0] now,
                             input logic [hcc_pkg::TEMP_W-1:0] temp,
                             input logic press, input logic level);
      hcc_pkg::req_type item;
      item.now_ms       = now;
      item.temperature  = temp;
      item.press_event  = press;
      item.button_level = level;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic write_reg(input logic [hcc_pkg::CSR_INDEX_W-1:0] index,
                            input logic [hcc_pkg::TIME_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // wait until every expected result beat has been taken
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // upper bits of the 10-bit registers carry junk that must be masked off
   task automatic configure(input logic [hcc_pkg::TEMP_W-1:0] max_t,
                            input logic [hcc_pkg::TIME_W-1:0] hold,
                            input logic [hcc_pkg::TEMP_W-1:0] blue,
                            input logic [hcc_pkg::TEMP_W-1:0] yellow,
                            input logic [hcc_pkg::TEMP_W-1:0] purple);
      drain();
      write_reg(hcc_pkg::CSR_HEAT_LIMIT, {JUNK_BITS'($urandom()), max_t});
      write_reg(hcc_pkg::CSR_HOLD_TIME_MS, hold);
      write_reg(hcc_pkg::CSR_BAND_BLUE_LIMIT, {JUNK_BITS'($urandom()), blue});
      write_reg(hcc_pkg::CSR_BAND_YELLOW_LIMIT, {JUNK_BITS'($urandom()), yellow});
      write_reg(hcc_pkg::CSR_BAND_PURPLE_LIMIT, {JUNK_BITS'($urandom()), purple});
      // unused indexes must be ignored
      write_reg(INDEX_BITS'(hcc_pkg::CSR_BAND_PURPLE_LIMIT + 1 + $urandom_range(2)),
                $urandom());
      limit_now = max_t;
   endtask

   function automatic logic [hcc_pkg::TIME_W-1:0] tick_ms();
      if ($urandom_range(49) == 0) begin
         clock_ms = $urandom();
      end else begin
         clock_ms += $urandom_range(40);
      end
      return clock_ms;
   endfunction

   // mostly a slow upward drift, often near the limit, now and then anywhere
   function automatic logic [hcc_pkg::TEMP_W-1:0] next_temp();
      int t;
      case ($urandom_range(9))
         0:       t = $urandom_range(TEMP_TOP);
         1, 2:    t = int'(limit_now) + int'($urandom_range(6)) - 3;
         default: t = int'(temp_now) + int'($urandom_range(22)) - 8;
      endcase
      if (t < 0) t = 0;
      if (t > TEMP_TOP) t = TEMP_TOP;
      temp_now = t[hcc_pkg::TEMP_W-1:0];
      return temp_now;
   endfunction

   task automatic run_random(input int passes);
      int sent;
      int held;
      int released;
      sent = 0;
      while (sent < passes) begin
         if ($urandom_range(99) < 15) begin
            drive_pass($urandom(), TEMP_BITS'($urandom_range(TEMP_TOP)),
                       1'($urandom_range(1)), 1'($urandom_range(1)));
            sent++;
         end else begin
            // press gesture: press while down, hold a while, then run released
            drive_pass(tick_ms(), next_temp(), 1'b1, 1'b1);
            held = $urandom_range(3);
            repeat (held) begin
               drive_pass(tick_ms(), next_temp(), ($urandom_range(99) < 20), 1'b1);
            end
            released = $urandom_range(1, 25);
            repeat (released) begin
               drive_pass(tick_ms(), next_temp(), ($urandom_range(99) < 5), 1'b0);
            end
            sent += 1 + held + released;
         end
      end
   endtask

   initial begin : stimulus
      int phase;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed passes on the reset settings
      drive_pass(32'd0, 10'd0, 1'b0, 1'b0);
      drive_pass(32'd10, 10'd1023, 1'b1, 1'b1);
      drive_pass(32'd20, 10'd1023, 1'b1, 1'b1);
      drive_pass(32'd30, 10'd100, 1'b0, 1'b0);
      drive_pass(32'd40, 10'd151, 1'b0, 1'b0);
      drive_pass(32'd50, 10'd231, 1'b0, 1'b0);
      drive_pass(32'd60, 10'd301, 1'b0, 1'b0);
      // press out of heating in the pass where the timer expires
      drive_pass(32'd10020, 10'd230, 1'b1, 1'b1);
      drive_pass(32'd10030, 10'd300, 1'b0, 1'b0);
      // press and release in one pass
      drive_pass(32'd10040, 10'd0, 1'b1, 1'b0);
      drive_pass(32'd10050, 10'd5, 1'b0, 1'b1);
      drive_pass(32'd10060, 10'd5, 1'b0, 1'b0);
      drive_pass(32'd10070, 10'd1023, 1'b1, 1'b0);
      // arm just before the time wraps, leave heating, come back, expire
      drive_pass(32'hFFFF_FFF0, 10'd400, 1'b0, 1'b0);
      drive_pass(32'hFFFF_FFF8, 10'd0, 1'b1, 1'b0);
      drive_pass(32'd0, 10'd0, 1'b1, 1'b0);
      drive_pass(32'd9990, 10'd0, 1'b0, 1'b0);
      drive_pass(32'd10000, 10'd1023, 1'b1, 1'b0);
      // standby press with the previous reading at the limit goes to finished
      drive_pass(32'd10010, 10'd700, 1'b1, 1'b0);
      drive_pass(32'd10020, 10'd512, 1'b0, 1'b1);
      drive_pass(32'hFFFF_FFFF, 10'd1023, 1'b1, 1'b1);
      drive_pass(32'd0, 10'd1023, 1'b0, 1'b1);

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: configure(10'd300, 32'd120, 10'd150, 10'd230, 10'd300);
            1: configure(10'd0, 32'd0, 10'd0, 10'd0, 10'd0);
            2: configure(10'd1023, 32'hFFFF_FFFF, 10'd1023, 10'd1023, 10'd1023);
            // overlapping bands
            3: configure(TEMP_BITS'($urandom_range(TEMP_TOP)), 32'd40,
                         10'd600, 10'd200, 10'd400);
            default: configure(TEMP_BITS'($urandom_range(TEMP_TOP)), $urandom_range(400),
                               TEMP_BITS'($urandom_range(TEMP_TOP)),
                               TEMP_BITS'($urandom_range(TEMP_TOP)),
                               TEMP_BITS'($urandom_range(TEMP_TOP)));
         endcase
         send_idle_pct = (phase == 4) ? 0 : 8;
         recv_idle_pct = (phase == 4) ? 0 : 8;
         if (phase == 5) begin
            hold_off_toggle <= ~hold_off_toggle;
         end
         run_random(PASSES_PER_PHASE);
      end

      drain();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("PASS heater_cycle_controller");
      end else begin
         $display("FAIL heater_cycle_controller");
      end
      $finish;
   end

endmodule
